[design/trle_pkg.sv]
// Shared types, constants and codes for the TGA RLE row encoder.
package trle_pkg;

	localparam int DEF_MAX_PACKET      = 128;
	localparam int DEF_PIXELS_PER_BEAT = 4;

	localparam int PIX_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int HDR_W       = 8;
	localparam int CNT_OUT_W   = 3;
	localparam int BEAT_SLOTS  = 4;
	localparam int BEAT_IDX_W  = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 1;

	localparam logic [HDR_W-1:0] RUN_BASE = 8'd128;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_FILL,
		ST_SEND
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic fill;
		logic beat_taken;
	} trle_cmd_t;

	typedef struct packed {
		logic job_pending;
		logic beat_full;
		logic pkt_done;
		logic more_jobs;
	} trle_sts_t;

endpackage

[design/trle_channels.sv]
// Handshake channel interfaces: pixel input, output beats and register writes.
interface trle_pix_if;
	import trle_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_zero;
	logic [BYTE_W-1:0] byte_one;
	logic [BYTE_W-1:0] byte_two;
	logic [BYTE_W-1:0] byte_three;
	logic              row_end;

	modport source (output valid, byte_zero, byte_one, byte_two, byte_three, row_end,
		input ready);
	modport sink (input valid, byte_zero, byte_one, byte_two, byte_three, row_end,
		output ready);
endinterface

interface trle_beat_if;
	import trle_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 has_header;
	logic [HDR_W-1:0]     header_byte;
	logic [CNT_OUT_W-1:0] pixel_count;
	logic [PIX_W-1:0]     pix_a;
	logic [PIX_W-1:0]     pix_b;
	logic [PIX_W-1:0]     pix_c;
	logic [PIX_W-1:0]     pix_d;
	logic                 packet_end;
	logic                 row_done;

	modport source (output valid, has_header, header_byte, pixel_count, pix_a, pix_b,
		pix_c, pix_d, packet_end, row_done, input ready);
	modport sink (input valid, has_header, header_byte, pixel_count, pix_a, pix_b,
		pix_c, pix_d, packet_end, row_done, output ready);
endinterface

interface trle_cfg_if;
	import trle_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/trle_ram.sv]
// Generic single-port-write RAM with registered read.
module trle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/trle_ctrl.sv]
// Controller: sequences item intake, store read setup, beat filling and beat hand-off.
module trle_ctrl import trle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  trle_sts_t sts,
	output trle_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = sts.job_pending ? ST_FILL : ST_IDLE;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.beat_full) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.beat_taken = 1'b1;
					if (sts.pkt_done && !sts.more_jobs) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_FILL;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/trle_datapath.sv]
// Datapath: encoder state, packet job queue, raw pixel store and beat assembly.
module trle_datapath import trle_pkg::*; #(
	parameter int MAX_PACKET      = DEF_MAX_PACKET,
	parameter int PIXELS_PER_BEAT = DEF_PIXELS_PER_BEAT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BYTE_W-1:0]     byte_zero,
	input  logic [BYTE_W-1:0]     byte_one,
	input  logic [BYTE_W-1:0]     byte_two,
	input  logic [BYTE_W-1:0]     byte_three,
	input  logic                  row_end,
	input  trle_cmd_t             cmd,
	output trle_sts_t             sts,
	output logic                  has_header,
	output logic [HDR_W-1:0]      header_byte,
	output logic [CNT_OUT_W-1:0]  pixel_count,
	output logic [PIX_W-1:0]      pix_a,
	output logic [PIX_W-1:0]      pix_b,
	output logic [PIX_W-1:0]      pix_c,
	output logic [PIX_W-1:0]      pix_d,
	output logic                  packet_end,
	output logic                  row_done
);

	localparam int CNT_W  = $clog2(MAX_PACKET + 1);
	localparam int ADDR_W = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
	localparam int SLOT_W = (PIXELS_PER_BEAT > 1) ? $clog2(PIXELS_PER_BEAT) : 1;

	localparam logic [CNT_W-1:0]  MAX_CNT      = CNT_W'(MAX_PACKET);
	localparam logic [HDR_W-1:0]  RUN_FULL_HDR = HDR_W'(128 + MAX_PACKET - 1);
	localparam logic [HDR_W-1:0]  RAW_FULL_HDR = HDR_W'(MAX_PACKET - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(PIXELS_PER_BEAT - 1);

	typedef struct packed {
		logic             hdr_en;
		logic             end_en;
		logic             row_last;
		logic [HDR_W-1:0] header;
		logic [CNT_W-1:0] nstore;
		logic             has_tail;
		logic [PIX_W-1:0] tail;
	} job_t;

	// configuration
	logic alpha_q, rle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 1'b0;
			rle_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA_MODE: alpha_q <= cfg_data[0];
				REG_RLE_ENABLE: rle_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// encoder state
	logic [PIX_W-1:0] prev_q;
	logic             have_q;
	logic [CNT_W-1:0] rc_q, dc_q;

	// job queue: a is current, b follows
	job_t a_q, b_q;
	logic a_v_q, b_v_q;

	// beat assembly
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic [SLOT_W-1:0] slot_q;
	logic [PIX_W-1:0]  beat_q [BEAT_SLOTS];
	logic              pkt_done_q;

	// intake decision
	logic [PIX_W-1:0]  pix_w;
	logic [PIX_W-1:0]  prev_n;
	logic              have_n;
	logic [CNT_W-1:0]  rc_n, dc_n;
	logic              m_v;
	job_t              m_job, f_job, pass_job;
	logic              st_we;
	logic [ADDR_W-1:0] st_waddr;
	logic [PIX_W-1:0]  st_rdata;

	assign pix_w = {alpha_q ? byte_three : {BYTE_W{1'b0}}, byte_zero, byte_one, byte_two};

	always_comb begin
		prev_n   = prev_q;
		have_n   = have_q;
		rc_n     = rc_q;
		dc_n     = dc_q;
		m_v      = 1'b0;
		m_job    = '0;
		f_job    = '0;
		st_we    = 1'b0;
		st_waddr = dc_q[ADDR_W-1:0];

		pass_job          = '0;
		pass_job.row_last = row_end;
		pass_job.has_tail = 1'b1;
		pass_job.tail     = pix_w;

		if (!have_q) begin
			prev_n = pix_w;
			have_n = 1'b1;
		end else begin
			if (pix_w != prev_q) begin
				if (rc_q != '0) begin
					m_v            = 1'b1;
					m_job.hdr_en   = 1'b1;
					m_job.end_en   = 1'b1;
					m_job.header   = RUN_BASE + HDR_W'(rc_q);
					m_job.has_tail = 1'b1;
					m_job.tail     = prev_q;
					rc_n           = '0;
					dc_n           = '0;
				end else begin
					st_we = 1'b1;
					dc_n  = dc_q + 1'b1;
				end
			end else begin
				if (dc_q != '0) begin
					m_v          = 1'b1;
					m_job.hdr_en = 1'b1;
					m_job.end_en = 1'b1;
					m_job.header = HDR_W'(dc_q - 1'b1);
					m_job.nstore = dc_q;
					dc_n         = '0;
					rc_n         = CNT_W'(1);
				end else begin
					rc_n = rc_q + 1'b1;
				end
			end
			if (rc_n >= MAX_CNT) begin
				m_v            = 1'b1;
				m_job          = '0;
				m_job.hdr_en   = 1'b1;
				m_job.end_en   = 1'b1;
				m_job.header   = RUN_FULL_HDR;
				m_job.has_tail = 1'b1;
				m_job.tail     = prev_q;
				rc_n           = '0;
			end else if (dc_n >= MAX_CNT) begin
				m_v          = 1'b1;
				m_job        = '0;
				m_job.hdr_en = 1'b1;
				m_job.end_en = 1'b1;
				m_job.header = RAW_FULL_HDR;
				m_job.nstore = dc_n;
				dc_n         = '0;
			end
			prev_n = pix_w;
		end

		// row flush
		f_job.hdr_en   = 1'b1;
		f_job.end_en   = 1'b1;
		f_job.row_last = 1'b1;
		f_job.has_tail = 1'b1;
		f_job.tail     = prev_n;
		if (rc_n != '0) begin
			f_job.header = RUN_BASE + HDR_W'(rc_n);
		end else begin
			f_job.header = HDR_W'(dc_n);
			f_job.nstore = dc_n;
		end
		if (row_end) begin
			have_n = 1'b0;
			rc_n   = '0;
			dc_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
			rc_q   <= '0;
			dc_q   <= '0;
		end else if (cmd.take && rle_q) begin
			prev_q <= prev_n;
			have_q <= have_n;
			rc_q   <= rc_n;
			dc_q   <= dc_n;
		end
	end

	// packet jobs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
		end else if (cmd.take) begin
			if (!rle_q) begin
				a_v_q <= 1'b1;
				b_v_q <= 1'b0;
			end else if (m_v) begin
				a_v_q <= 1'b1;
				b_v_q <= row_end;
			end else begin
				a_v_q <= row_end;
				b_v_q <= 1'b0;
			end
		end else if (cmd.beat_taken && pkt_done_q) begin
			a_v_q <= b_v_q;
			b_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			a_q <= !rle_q ? pass_job : (m_v ? m_job : f_job);
			b_q <= f_job;
		end else if (cmd.beat_taken && pkt_done_q) begin
			a_q <= b_q;
		end
	end

	// raw store; read address runs one step ahead so read data matches pos_q
	always_comb begin
		pos_d = pos_q;
		if (cmd.take) begin
			pos_d = '0;
		end else if (cmd.fill) begin
			pos_d = pos_q + 1'b1;
		end else if (cmd.beat_taken && pkt_done_q) begin
			pos_d = '0;
		end
	end

	trle_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_PACKET),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (cmd.take && rle_q && st_we),
		.waddr(st_waddr),
		.wdata(prev_q),
		.raddr(pos_d[ADDR_W-1:0]),
		.rdata(st_rdata)
	);

	// beat fill
	logic [CNT_W-1:0] a_total;
	logic             last_in_pkt, last_in_beat;
	logic [PIX_W-1:0] fill_pix;

	assign a_total      = a_q.nstore + CNT_W'(a_q.has_tail);
	assign last_in_pkt  = ({1'b0, pos_q} + 1'b1) == {1'b0, a_total};
	assign last_in_beat = last_in_pkt || (slot_q == SLOT_LAST);
	assign fill_pix     = (pos_q < a_q.nstore) ? st_rdata : a_q.tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			slot_q     <= '0;
			pkt_done_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			if (cmd.take) begin
				slot_q     <= '0;
				pkt_done_q <= 1'b0;
			end else if (cmd.fill) begin
				slot_q     <= last_in_beat ? '0 : slot_q + 1'b1;
				pkt_done_q <= last_in_pkt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			for (int i = 0; i < BEAT_SLOTS; i++) begin
				if (BEAT_IDX_W'(i) == BEAT_IDX_W'(slot_q)) begin
					beat_q[i] <= fill_pix;
				end else if (slot_q == '0) begin
					beat_q[i] <= '0;
				end
			end
			if (slot_q == '0) begin
				has_header  <= (pos_q == '0) && a_q.hdr_en;
				header_byte <= ((pos_q == '0) && a_q.hdr_en) ? a_q.header : '0;
			end
			pixel_count <= CNT_OUT_W'(slot_q) + 1'b1;
			packet_end  <= last_in_pkt && a_q.end_en;
			row_done    <= last_in_pkt && a_q.row_last;
		end
	end

	assign pix_a = beat_q[0];
	assign pix_b = beat_q[1];
	assign pix_c = beat_q[2];
	assign pix_d = beat_q[3];

	assign sts.job_pending = a_v_q;
	assign sts.beat_full   = last_in_beat;
	assign sts.pkt_done    = pkt_done_q;
	assign sts.more_jobs   = b_v_q;

endmodule

[design/tga_rle_row_encoder_core.sv]
// Top level of the TGA RLE row encoder: controller, datapath and channel wiring.
//
// Takes one pixel item at a time and returns the TGA packets it closes as beats
// of up to PIXELS_PER_BEAT pixels. Each item passes through intake and a store
// read setup step; each beat is then filled pixel by pixel, since raw pixels
// leave the store through its single read port, and is held until the output
// takes it. The next pixel is taken once all beats of the current one are
// delivered. The store needs no clearing after reset. Register writes are
// always taken.
module tga_rle_row_encoder_core import trle_pkg::*; #(
	parameter int MAX_PACKET      = DEF_MAX_PACKET,
	parameter int PIXELS_PER_BEAT = DEF_PIXELS_PER_BEAT
) (
	input logic         clk,
	input logic         arst_n,
	trle_cfg_if.sink    cfg,
	trle_pix_if.sink    pixels,
	trle_beat_if.source beats
);

	trle_cmd_t cmd;
	trle_sts_t sts;
	logic      in_ready, out_valid;

	assign cfg.ready    = 1'b1;
	assign pixels.ready = in_ready;
	assign beats.valid  = out_valid;

	trle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(beats.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	trle_datapath #(
		.MAX_PACKET     (MAX_PACKET),
		.PIXELS_PER_BEAT(PIXELS_PER_BEAT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.byte_zero  (pixels.byte_zero),
		.byte_one   (pixels.byte_one),
		.byte_two   (pixels.byte_two),
		.byte_three (pixels.byte_three),
		.row_end    (pixels.row_end),
		.cmd        (cmd),
		.sts        (sts),
		.has_header (beats.has_header),
		.header_byte(beats.header_byte),
		.pixel_count(beats.pixel_count),
		.pix_a      (beats.pix_a),
		.pix_b      (beats.pix_b),
		.pix_c      (beats.pix_c),
		.pix_d      (beats.pix_d),
		.packet_end (beats.packet_end),
		.row_done   (beats.row_done)
	);

endmodule
